// ===== rtl/core/amix_pkg.sv =====
// ----------------------------------------------------------------------------
// amix_pkg
// Shared constants and types for the multichannel audio mixer.
// ----------------------------------------------------------------------------
package amix_pkg;

    localparam int NUM_CHAN    = 16;
    localparam int OFFSET_BITS = 24;
    localparam int CHAN_IDX_W  = (NUM_CHAN > 16) ? 4 :
                                 ((NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1);

    localparam int OUT_OFF_W   = 24;
    localparam int SMP_W       = 16;
    localparam int VOL_W       = 7;
    localparam int ACC_W       = 22;
    localparam int WORD_W      = 18;

    localparam int STEP_BYTES  = 4;

    // |sample| * volume fits in 22 bits; x / 127 == (x * RECIP) >> RECIP_SHIFT
    localparam int MAG_W       = 22;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP = 23'd4227331;
    localparam int QUO_W       = 16;

    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = 2;
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = 2;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_MIX    = 1'b1;

    typedef struct packed {
        logic [OUT_OFF_W-1:0]    next_offset;
        logic                    channel_active;
        logic                    finish;
        logic signed [SMP_W-1:0] smp;
        logic [VOL_W-1:0]        vol;
        logic signed [SMP_W-1:0] mus;
    } cmd_t;

    typedef struct packed {
        logic [OUT_OFF_W-1:0] next_offset;
        logic                 channel_active;
        logic                 mix_valid;
        logic [WORD_W-1:0]    mixed_word;
    } result_t;

endpackage

// ===== rtl/core/multichannel_audio_mixer_top.sv =====
// ----------------------------------------------------------------------------
// multichannel_audio_mixer_top
// Up to 16-channel PCM mixer with volume scaling and output saturation.
// Path: request queue, stage 1 and stage 2 registers, then result queue.
// Throughput: one request per cycle while full is low, set by the channel
// table update and a fully pipelined multiply / divide / accumulate path.
// Reset: rst_n clears channel table, accumulator, music enable and queues at
// once; requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module multichannel_audio_mixer_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                music_enable_we,
    input  logic                music_enable,
    input  logic                push,
    output logic                full,
    input  logic                operation,
    input  logic [3:0]          channel,
    input  logic [23:0]         length_bytes,
    input  logic [6:0]          volume,
    input  logic signed [15:0]  channel_sample,
    input  logic signed [15:0]  music_sample,
    input  logic                frame_last,
    input  logic                pop,
    output logic                empty,
    output logic [23:0]         next_offset,
    output logic                channel_active,
    output logic                mix_valid,
    output logic [17:0]         mixed_word
);

    amix_pkg::cmd_t    front_cmd;
    amix_pkg::cmd_t    cmdq_dout;
    amix_pkg::result_t result;
    logic              accept;
    logic              cmdq_full;
    logic              cmdq_empty;
    logic              cmdq_pop;

    assign full   = cmdq_full;
    assign accept = push && !cmdq_full;

    amix_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .music_enable_we (music_enable_we),
        .music_enable    (music_enable),
        .accept          (accept),
        .operation       (operation),
        .channel         (channel),
        .length_bytes    (length_bytes),
        .volume          (volume),
        .channel_sample  (channel_sample),
        .music_sample    (music_sample),
        .frame_last      (frame_last),
        .cmd             (front_cmd)
    );

    amix_cmdq u_cmdq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .full  (cmdq_full),
        .pop   (cmdq_pop),
        .dout  (cmdq_dout),
        .empty (cmdq_empty)
    );

    amix_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmdq_dout),
        .cmd_empty (cmdq_empty),
        .cmd_pop   (cmdq_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign next_offset    = result.next_offset;
    assign channel_active = result.channel_active;
    assign mix_valid      = result.mix_valid;
    assign mixed_word     = result.mixed_word;

    a_word_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !mix_valid) |-> (mixed_word == '0))
        else $error("mixed_word nonzero without a finished sample");

    a_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && mix_valid) |-> (mixed_word[1:0] == 2'b00))
        else $error("mixed_word not a multiple of four");

    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !cmdq_empty)
        else $error("accepted request missing from request queue");

endmodule

// ===== rtl/core/amix_cmdq.sv =====
// ----------------------------------------------------------------------------
// amix_cmdq
// Short request queue between the channel front end and the mix back end.
// ----------------------------------------------------------------------------
module amix_cmdq
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  amix_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output amix_pkg::cmd_t dout,
    output logic           empty
);

    amix_pkg::cmd_t                    mem_reg [amix_pkg::CMDQ_DEPTH];
    logic [amix_pkg::CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [amix_pkg::CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [amix_pkg::CMDQ_PTR_W:0]     cnt_reg;
    logic [amix_pkg::CMDQ_PTR_W:0]     cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (cnt_reg == (amix_pkg::CMDQ_PTR_W+1)'(amix_pkg::CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/core/amix_front.sv =====
// ----------------------------------------------------------------------------
// amix_front
// Channel table: takes start and mix requests, tracks offset, length, volume
// and active flag per channel, and issues scaled-mix requests downstream.
// ----------------------------------------------------------------------------
module amix_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                music_enable_we,
    input  logic                                music_enable,
    input  logic                                accept,
    input  logic                                operation,
    input  logic [3:0]                          channel,
    input  logic [23:0]                         length_bytes,
    input  logic [amix_pkg::VOL_W-1:0]          volume,
    input  logic signed [amix_pkg::SMP_W-1:0]   channel_sample,
    input  logic signed [amix_pkg::SMP_W-1:0]   music_sample,
    input  logic                                frame_last,
    output amix_pkg::cmd_t                      cmd
);

    localparam int OFF_W = amix_pkg::OFFSET_BITS;
    localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

    logic                          music_en_reg;
    logic                          active_reg [amix_pkg::NUM_CHAN];
    logic [OFF_W-1:0]              offset_reg [amix_pkg::NUM_CHAN];
    logic [OFF_W-1:0]              length_reg [amix_pkg::NUM_CHAN];
    logic [amix_pkg::VOL_W-1:0]    volume_reg [amix_pkg::NUM_CHAN];

    logic [amix_pkg::CHAN_IDX_W-1:0] idx;
    logic                          chan_ok;
    logic                          cur_act;
    logic [OFF_W-1:0]              cur_off;
    logic [OFF_W-1:0]              cur_len;
    logic [amix_pkg::VOL_W-1:0]    cur_vol;
    logic                          play;
    logic [OFF_W-1:0]              step_off;
    logic [OFF_W-1:0]              off_next;

    assign idx     = channel[amix_pkg::CHAN_IDX_W-1:0];
    assign chan_ok = (32'(channel) < 32'(amix_pkg::NUM_CHAN));
    assign cur_act = active_reg[idx];
    assign cur_off = offset_reg[idx];
    assign cur_len = length_reg[idx];
    assign cur_vol = volume_reg[idx];
    assign play    = cur_act && (cur_off < cur_len);

    // saturate at the top of the offset range
    assign step_off = (cur_off > (OFF_MAX - OFF_W'(amix_pkg::STEP_BYTES))) ? OFF_MAX :
                      (cur_off + OFF_W'(amix_pkg::STEP_BYTES));
    assign off_next = play ? step_off : cur_off;

    always_comb
    begin
        cmd = '0;
        if (operation == amix_pkg::OP_START)
        begin
            cmd.channel_active = 1'b1;
        end
        else
        begin
            if (chan_ok)
            begin
                cmd.next_offset    = amix_pkg::OUT_OFF_W'(off_next);
                cmd.channel_active = play;
                cmd.vol            = play ? cur_vol : '0;
            end
            cmd.smp    = channel_sample;
            cmd.finish = frame_last;
            cmd.mus    = music_en_reg ? music_sample : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_en_reg <= 1'b0;
            for (int i = 0; i < amix_pkg::NUM_CHAN; i++)
            begin
                active_reg[i] <= 1'b0;
                offset_reg[i] <= '0;
                length_reg[i] <= '0;
                volume_reg[i] <= '0;
            end
        end
        else
        begin
            if (music_enable_we)
            begin
                music_en_reg <= music_enable;
            end
            if (accept && chan_ok)
            begin
                if (operation == amix_pkg::OP_START)
                begin
                    active_reg[idx] <= 1'b1;
                    offset_reg[idx] <= '0;
                    length_reg[idx] <= OFF_W'(length_bytes);
                    volume_reg[idx] <= volume;
                end
                else
                begin
                    active_reg[idx] <= play;
                    offset_reg[idx] <= off_next;
                end
            end
        end
    end

endmodule

// ===== rtl/core/amix_back.sv =====
// ----------------------------------------------------------------------------
// amix_back
// Mix pipeline: volume multiply, divide by 127, saturating accumulate, frame
// finish and clamp, then a result queue toward the consumer.
// ----------------------------------------------------------------------------
module amix_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  amix_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    input  logic              pop,
    output logic              empty,
    output amix_pkg::result_t result
);

    typedef struct packed {
        logic [amix_pkg::OUT_OFF_W-1:0]    next_offset;
        logic                              channel_active;
        logic                              finish;
        logic                              neg;
        logic signed [amix_pkg::SMP_W-1:0] mus;
    } stage_t;

    localparam int PROD_W = amix_pkg::MAG_W + amix_pkg::RECIP_W;
    localparam int SUM_W  = amix_pkg::ACC_W + 1;
    localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'((1 <<< (amix_pkg::ACC_W-1)) - 1);
    localparam logic signed [SUM_W-1:0] ACC_LO = -SUM_W'(1 <<< (amix_pkg::ACC_W-1));
    localparam logic signed [SUM_W-1:0] S16_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] S16_LO = -SUM_W'(32768);

    logic                                s1_v_reg;
    stage_t                              s1_reg;
    logic [amix_pkg::MAG_W-1:0]          s1_mag_reg;
    logic                                s2_v_reg;
    stage_t                              s2_reg;
    logic [amix_pkg::QUO_W-1:0]          s2_quo_reg;
    logic signed [amix_pkg::ACC_W-1:0]   acc_reg;
    logic signed [amix_pkg::ACC_W-1:0]   acc_next;

    amix_pkg::result_t                   outq_reg [amix_pkg::OUTQ_DEPTH];
    logic [amix_pkg::OUTQ_PTR_W-1:0]     wr_ptr_reg;
    logic [amix_pkg::OUTQ_PTR_W-1:0]     rd_ptr_reg;
    logic [amix_pkg::OUTQ_PTR_W:0]       cnt_reg;
    logic [amix_pkg::OUTQ_PTR_W:0]       cnt_next;

    logic [amix_pkg::OUTQ_PTR_W+1:0]     reserved;
    logic [amix_pkg::SMP_W:0]            abs_smp;
    logic [amix_pkg::MAG_W-1:0]          mag_next;
    stage_t                              s1_next;
    logic [PROD_W-1:0]                   prod;
    logic signed [amix_pkg::QUO_W:0]     scaled;
    logic signed [SUM_W-1:0]             acc_sum;
    logic signed [amix_pkg::ACC_W-1:0]   acc_sat;
    logic signed [SUM_W-1:0]             frame_sum;
    logic [amix_pkg::SMP_W-1:0]          frame_s16;
    amix_pkg::result_t                   res_next;
    logic                                do_pop;

    // issue only while the result queue can absorb everything in flight
    assign reserved = (amix_pkg::OUTQ_PTR_W+2)'(cnt_reg)
                    + (amix_pkg::OUTQ_PTR_W+2)'(s1_v_reg)
                    + (amix_pkg::OUTQ_PTR_W+2)'(s2_v_reg);
    assign cmd_pop  = !cmd_empty &&
                      (reserved < (amix_pkg::OUTQ_PTR_W+2)'(amix_pkg::OUTQ_DEPTH));

    // stage 1: magnitude times volume
    assign abs_smp  = cmd.smp[amix_pkg::SMP_W-1] ?
                      ((amix_pkg::SMP_W+1)'(0) - {1'b1, cmd.smp}) : {1'b0, cmd.smp};
    assign mag_next = amix_pkg::MAG_W'(abs_smp) * amix_pkg::MAG_W'(cmd.vol);

    always_comb
    begin
        s1_next.next_offset    = cmd.next_offset;
        s1_next.channel_active = cmd.channel_active;
        s1_next.finish         = cmd.finish;
        s1_next.neg            = cmd.smp[amix_pkg::SMP_W-1];
        s1_next.mus            = cmd.mus;
    end

    // stage 2: divide by 127 through reciprocal
    assign prod = PROD_W'(s1_mag_reg) * PROD_W'(amix_pkg::RECIP);

    // stage 3: accumulate, finish frame
    assign scaled  = s2_reg.neg ? -$signed({1'b0, s2_quo_reg}) : $signed({1'b0, s2_quo_reg});
    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(scaled);

    always_comb
    begin
        if (acc_sum > ACC_HI)
        begin
            acc_sat = amix_pkg::ACC_W'(ACC_HI);
        end
        else if (acc_sum < ACC_LO)
        begin
            acc_sat = amix_pkg::ACC_W'(ACC_LO);
        end
        else
        begin
            acc_sat = amix_pkg::ACC_W'(acc_sum);
        end
    end

    assign frame_sum = SUM_W'(acc_sat) + SUM_W'(s2_reg.mus);

    always_comb
    begin
        if (frame_sum > S16_HI)
        begin
            frame_s16 = 16'h7FFF;
        end
        else if (frame_sum < S16_LO)
        begin
            frame_s16 = 16'h8000;
        end
        else
        begin
            frame_s16 = frame_sum[amix_pkg::SMP_W-1:0];
        end
    end

    always_comb
    begin
        res_next.next_offset    = s2_reg.next_offset;
        res_next.channel_active = s2_reg.channel_active;
        res_next.mix_valid      = s2_reg.finish;
        res_next.mixed_word     = s2_reg.finish ?
                                  {~frame_s16[15], frame_s16[14:0], 2'b00} : '0;
        acc_next = acc_reg;
        if (s2_v_reg)
        begin
            acc_next = s2_reg.finish ? '0 : acc_sat;
        end
    end

    // result queue
    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign result = outq_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (s2_v_reg && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !s2_v_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            acc_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            s1_v_reg <= cmd_pop;
            s2_v_reg <= s1_v_reg;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            if (s2_v_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_reg     <= s1_next;
            s1_mag_reg <= mag_next;
        end
        if (s1_v_reg)
        begin
            s2_reg     <= s1_reg;
            s2_quo_reg <= prod[amix_pkg::RECIP_SHIFT +: amix_pkg::QUO_W];
        end
        if (s2_v_reg)
        begin
            outq_reg[wr_ptr_reg] <= res_next;
        end
    end

endmodule
